[rtl/core/bmpd_pkg.sv]
// Package for the BMP pixel stream decoder.
// Holds the parser phase type, status codes, header byte positions and the result beat type.
// Depends on nothing.
package bmpd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  localparam logic [1:0] ST_PIXEL        = 2'd0;
  localparam logic [1:0] ST_BAD_SIG      = 2'd1;
  localparam logic [1:0] ST_SMALL_OFFSET = 2'd2;

  localparam logic [7:0] SIG_B      = 8'd66;
  localparam logic [7:0] SIG_M      = 8'd77;
  localparam logic [7:0] DEPTH_32   = 8'd32;
  localparam logic [7:0] MIN_OFFSET = 8'd29;
  localparam logic [7:0] COUNT_MAX  = 8'd255;

  localparam logic [7:0] IDX_SIG_B     = 8'd0;
  localparam logic [7:0] IDX_SIG_M     = 8'd1;
  localparam logic [7:0] IDX_OFFSET    = 8'd10;
  localparam logic [7:0] IDX_WIDTH_LO  = 8'd18;
  localparam logic [7:0] IDX_WIDTH_HI  = 8'd19;
  localparam logic [7:0] IDX_HEIGHT_LO = 8'd22;
  localparam logic [7:0] IDX_HEIGHT_HI = 8'd23;
  localparam logic [7:0] IDX_DEPTH     = 8'd28;

  localparam logic [1:0] BIP_BLUE  = 2'd0;
  localparam logic [1:0] BIP_GREEN = 2'd1;
  localparam logic [1:0] BIP_RED   = 2'd2;
  localparam logic [1:0] BIP_SKIP  = 2'd3;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] column;
    logic [15:0] row;
    logic        last_pixel;
    logic [1:0]  status;
  } pix_t;

endpackage

[rtl/core/bmpd_in_reg.sv]
// Input register of the BMP pixel stream decoder.
// Holds one byte beat until the parser consumes it; uses nothing from the package.
// Stall toward the source follows the result register's advance signal.
module bmpd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       file_start,
  input  logic       advance,
  output logic       held,
  output logic [7:0] held_byte,
  output logic       held_start
);

  assign byte_stall = held && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!byte_stall) begin
      held <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      held_byte  <= data_byte;
      held_start <= file_start;
    end
  end

endmodule

[rtl/core/bmpd_parse.sv]
// Header parser and pixel assembler of the BMP pixel stream decoder.
// Keeps all parser state and forms at most one result beat per consumed byte.
// Depends on bmpd_pkg.
module bmpd_parse #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  logic          file_start,
  output logic          res_hit,
  output bmpd_pkg::pix_t res
);
  import bmpd_pkg::*;

  localparam int CW1 = COORD_BITS + 1;

  phase_t                phase, phase_cur, phase_next;
  logic [7:0]            byte_count, bc_cur, byte_count_next;
  logic [7:0]            data_offset, data_offset_next;
  logic [COORD_BITS-1:0] image_width, image_width_next;
  logic [COORD_BITS-1:0] image_height, image_height_next;
  logic                  four_byte_pixels, four_byte_pixels_next;
  logic [COORD_BITS-1:0] column_count, col_cur, column_count_next;
  logic [COORD_BITS-1:0] row_count, row_cur, row_count_next;
  logic [1:0]            byte_in_pixel, bip_cur, byte_in_pixel_next;
  logic [1:0]            pad_left, pad_cur, pad_left_next;
  logic [7:0]            held_blue, held_blue_next;
  logic [7:0]            held_green, held_green_next;

  logic [15:0]           width_wide;
  logic [15:0]           height_wide;
  logic                  col_end;
  logic                  row_end;
  logic [COORD_BITS-1:0] row_out;

  assign phase_cur = file_start ? PH_HEADER : phase;
  assign bc_cur    = file_start ? 8'd0 : byte_count;
  assign col_cur   = file_start ? '0 : column_count;
  assign row_cur   = file_start ? '0 : row_count;
  assign bip_cur   = file_start ? BIP_BLUE : byte_in_pixel;
  assign pad_cur   = file_start ? 2'd0 : pad_left;

  assign width_wide  = 16'(image_width);
  assign height_wide = 16'(image_height);
  assign col_end = ({1'b0, col_cur} + CW1'(1)) == {1'b0, image_width};
  assign row_end = ({1'b0, row_cur} + CW1'(1)) == {1'b0, image_height};
  assign row_out = image_height - COORD_BITS'(1) - row_cur;

  always_comb begin
    phase_next            = phase_cur;
    byte_count_next       = bc_cur;
    data_offset_next      = data_offset;
    image_width_next      = image_width;
    image_height_next     = image_height;
    four_byte_pixels_next = four_byte_pixels;
    column_count_next     = col_cur;
    row_count_next        = row_cur;
    byte_in_pixel_next    = bip_cur;
    pad_left_next         = pad_cur;
    held_blue_next        = held_blue;
    held_green_next       = held_green;
    res_hit               = 1'b0;
    res                   = '0;

    case (phase_cur)
      PH_PIXELS: begin
        if (pad_cur != 2'd0) begin
          pad_left_next = pad_cur - 2'd1;
        end else begin
          case (bip_cur)
            BIP_BLUE: begin
              held_blue_next     = data_byte;
              byte_in_pixel_next = BIP_GREEN;
            end
            BIP_GREEN: begin
              held_green_next    = data_byte;
              byte_in_pixel_next = BIP_RED;
            end
            BIP_RED: begin
              res_hit        = 1'b1;
              res.red        = data_byte;
              res.green      = held_green;
              res.blue       = held_blue;
              res.column     = 16'(col_cur);
              res.row        = 16'(row_out);
              res.last_pixel = col_end && row_end;
              res.status     = ST_PIXEL;
              if (col_end && row_end) begin
                phase_next = PH_IDLE;
              end else if (four_byte_pixels) begin
                byte_in_pixel_next = BIP_SKIP;
              end else begin
                byte_in_pixel_next = BIP_BLUE;
                if (col_end) begin
                  column_count_next = '0;
                  row_count_next    = row_cur + COORD_BITS'(1);
                  pad_left_next     = image_width[1:0];
                end else begin
                  column_count_next = col_cur + COORD_BITS'(1);
                end
              end
            end
            default: begin
              byte_in_pixel_next = BIP_BLUE;
              if (col_end) begin
                column_count_next = '0;
                row_count_next    = row_cur + COORD_BITS'(1);
                pad_left_next     = 2'd0;
              end else begin
                column_count_next = col_cur + COORD_BITS'(1);
              end
            end
          endcase
        end
      end
      PH_HEADER: begin
        case (bc_cur)
          IDX_SIG_B: begin
            if (data_byte != SIG_B) begin
              phase_next = PH_IDLE;
              res_hit    = 1'b1;
              res.status = ST_BAD_SIG;
            end
          end
          IDX_SIG_M: begin
            if (data_byte != SIG_M) begin
              phase_next = PH_IDLE;
              res_hit    = 1'b1;
              res.status = ST_BAD_SIG;
            end
          end
          IDX_OFFSET: begin
            data_offset_next = data_byte;
            if (data_byte < MIN_OFFSET) begin
              phase_next = PH_IDLE;
              res_hit    = 1'b1;
              res.status = ST_SMALL_OFFSET;
            end
          end
          IDX_WIDTH_LO:  image_width_next  = COORD_BITS'({8'd0, data_byte});
          IDX_WIDTH_HI:  image_width_next  = COORD_BITS'({data_byte, width_wide[7:0]});
          IDX_HEIGHT_LO: image_height_next = COORD_BITS'({8'd0, data_byte});
          IDX_HEIGHT_HI: image_height_next = COORD_BITS'({data_byte, height_wide[7:0]});
          IDX_DEPTH:     four_byte_pixels_next = (data_byte == DEPTH_32);
          default: begin
          end
        endcase

        if (!res_hit) begin
          if (bc_cur >= MIN_OFFSET && bc_cur == data_offset) begin
            column_count_next = '0;
            row_count_next    = '0;
            pad_left_next     = 2'd0;
            if (image_width == '0 || image_height == '0) begin
              phase_next         = PH_IDLE;
              byte_in_pixel_next = BIP_BLUE;
            end else begin
              phase_next         = PH_PIXELS;
              held_blue_next     = data_byte;
              byte_in_pixel_next = BIP_GREEN;
            end
          end else if (bc_cur < COUNT_MAX) begin
            byte_count_next = bc_cur + 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_count    <= 8'd0;
      column_count  <= '0;
      row_count     <= '0;
      byte_in_pixel <= BIP_BLUE;
      pad_left      <= 2'd0;
    end else if (step) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      byte_in_pixel <= byte_in_pixel_next;
      pad_left      <= pad_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data_offset      <= data_offset_next;
      image_width      <= image_width_next;
      image_height     <= image_height_next;
      four_byte_pixels <= four_byte_pixels_next;
      held_blue        <= held_blue_next;
      held_green       <= held_green_next;
    end
  end

endmodule

[rtl/core/bmpd_out_reg.sv]
// Result register of the BMP pixel stream decoder.
// Holds one result beat until the sink takes it and tells the parser when it may advance.
// Depends on bmpd_pkg.
module bmpd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           res_hit,
  input  bmpd_pkg::pix_t res,
  output logic           advance,
  output logic           pix_valid,
  input  logic           pix_stall,
  output bmpd_pkg::pix_t beat
);
  import bmpd_pkg::*;

  assign advance = !pix_valid || !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (advance) begin
      pix_valid <= step && res_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && res_hit) begin
      beat <= res;
    end
  end

endmodule

[rtl/core/bmp_pixel_stream_decoder.sv]
// BMP pixel stream decoder: takes a BMP file one byte per beat and gives one pixel beat per
// pixel, or a single error beat for a bad signature or a pixel offset below 29. One byte is
// taken every cycle while the result side keeps up; a byte's result passes from the input register
// through the parser logic into the result register. A stall on the result side reaches the
// byte side in the same cycle once both registers are full. Width and height are kept in
// COORD_BITS bits.
module bmp_pixel_stream_decoder #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  output logic        pix_valid,
  input  logic        pix_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [15:0] column,
  output logic [15:0] row,
  output logic        last_pixel,
  output logic [1:0]  status
);
  import bmpd_pkg::*;

  logic       advance;
  logic       held;
  logic [7:0] held_byte;
  logic       held_start;
  logic       step;
  logic       res_hit;
  pix_t       res;
  pix_t       beat;

  assign step = held && advance;

  bmpd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .file_start (file_start),
    .advance    (advance),
    .held       (held),
    .held_byte  (held_byte),
    .held_start (held_start)
  );

  bmpd_parse #(
    .COORD_BITS (COORD_BITS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (held_byte),
    .file_start (held_start),
    .res_hit    (res_hit),
    .res        (res)
  );

  bmpd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_hit   (res_hit),
    .res       (res),
    .advance   (advance),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .beat      (beat)
  );

  assign red        = beat.red;
  assign green      = beat.green;
  assign blue       = beat.blue;
  assign column     = beat.column;
  assign row        = beat.row;
  assign last_pixel = beat.last_pixel;
  assign status     = beat.status;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (held && pix_valid && pix_stall))
    else $error("byte side stalled while the result register could take a beat");

  a_error_beat_zero: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && status != ST_PIXEL) |->
      (red == 8'd0 && green == 8'd0 && blue == 8'd0 && column == 16'd0 &&
       row == 16'd0 && !last_pixel))
    else $error("error beat carries pixel data");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && last_pixel) |-> (status == ST_PIXEL))
    else $error("last pixel flag on an error beat");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (step && res_hit) |=> pix_valid)
    else $error("result beat lost on its way to the result register");
`endif

endmodule
